>>> rtl/aligned_first_fit_allocator_assert.svh
// ----------------------------------------------------------------------------
// Aligned first-fit allocator assertion macros
// Concurrent check macros that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define ALIGNED_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AFA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
`define AFA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`else
`define AFA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define AFA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> rtl/afa_pkg.sv
// ----------------------------------------------------------------------------
// Aligned first-fit allocator package
// Word types, status and opcode codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package afa_pkg;

    localparam int MAX_ALLOCS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 48;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_VALIDATE = 2'd2,
        OP_RSVD     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_STALE    = 3'd2,
        ST_OOM      = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_EPOCH    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_FIT,
        S_GAP,
        S_FINAL,
        S_FFIT,
        S_INS,
        S_MATCH,
        S_DEL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] req_size;
        logic [47:0] req_alignment;
        logic [63:0] req_generation;
        logic [63:0] handle_id;
        logic [47:0] handle_offset;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] result_id;
        logic [47:0] result_offset;
        logic [47:0] bytes_in_use;
    } out_word_t;

endpackage

>>> rtl/afa_table.sv
// ----------------------------------------------------------------------------
// Allocation table
// Entry memory with one read port and one write port; moves one entry a cycle.
// ----------------------------------------------------------------------------
module afa_table #(
    parameter int MAX_ALLOCS = afa_pkg::MAX_ALLOCS_DEF,
    parameter int IW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1
) (
    input  logic          clk,
    input  logic [IW-1:0] raddr,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [207:0]  wdata,
    output logic [207:0]  rdata
);
    logic [207:0] mem [MAX_ALLOCS];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/aligned_first_fit_allocator.sv
// An allocate walks the table entry by entry through the align, fit and gap
// steps, then shifts entries up to open the insert slot; release searches
// entry by entry and shifts the later entries down; validate only searches.
// One request at a time: the single table read port and shared adder set it.
// Reset: table empty, next id one, capacity and epoch zero; no clearing pass.
// ----------------------------------------------------------------------------
// Aligned first-fit allocator
// Sequenced first-fit walk over a sorted allocation table.
// ----------------------------------------------------------------------------
`include "aligned_first_fit_allocator_assert.svh"
module aligned_first_fit_allocator #(
    parameter int MAX_ALLOCS = afa_pkg::MAX_ALLOCS_DEF,
    parameter int ADDR_BITS  = afa_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  afa_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output afa_pkg::out_word_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);
    localparam int IW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int CW = $clog2(MAX_ALLOCS + 1);
    localparam logic [47:0] AMASK = (ADDR_BITS >= 48) ? {48{1'b1}}
                                    : 48'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_ALLOCS);

    afa_pkg::state_t state_reg, state_next;
    afa_pkg::in_word_t req_reg;
    logic [47:0] cap_reg;
    logic [63:0] epoch_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0] nid_reg, nid_next;
    logic [47:0] live_reg, live_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [47:0] cand_reg, cand_next;
    logic        oval_reg;
    afa_pkg::out_word_t odata_reg, odata_next;

    logic [IW-1:0] raddr, waddr;
    logic          we;
    logic [207:0]  wdata, rdata;
    logic [63:0]   e_id;
    logic [47:0]   e_off, e_size, e_align;
    logic [47:0]   size, align, hoff;

    assign size  = req_reg.req_size & AMASK;
    assign align = req_reg.req_alignment & AMASK;
    assign hoff  = req_reg.handle_offset & AMASK;
    assign {e_id, e_off, e_size, e_align} = rdata;

    afa_table #(.MAX_ALLOCS(MAX_ALLOCS), .IW(IW)) u_table (
        .clk(clk), .raddr(raddr), .we(we), .waddr(waddr),
        .wdata(wdata), .rdata(rdata)
    );

    // Shared adder: operands picked by state
    logic [48:0] add_a, add_b, add_s;
    assign add_s = add_a + add_b;
    logic [47:0] rem, inc;
    assign rem = cand_reg[47:0] & (align - 48'd1);
    assign inc = (rem == 48'd0) ? 48'd0 : align - rem;

    always_comb
    begin
        add_a = {1'b0, cand_reg[47:0]};
        add_b = {1'b0, inc};
        case (state_reg)
            afa_pkg::S_FIT, afa_pkg::S_FFIT: add_b = {1'b0, size};
            afa_pkg::S_GAP:
            begin
                add_a = {1'b0, e_off};
                add_b = {1'b0, e_size};
            end
            default: ;
        endcase
    end

    logic idle_cfg;
    assign idle_cfg  = (state_reg == afa_pkg::S_IDLE) && !oval_reg;
    assign cfg_ready = idle_cfg;
    assign in_stall  = !idle_cfg;
    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

    logic fit_ok, gen_bad, is_p2;
    assign fit_ok  = !add_s[48] && (add_s[47:0] <= cap_reg) && (add_s[47:0] <= AMASK);
    assign gen_bad = (req_reg.req_generation == 64'd0)
                     || (req_reg.req_generation != epoch_reg);
    assign is_p2   = (align != 48'd0) && ((align & (align - 48'd1)) == 48'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            afa_pkg::S_IDLE:
                if (in_valid && !in_stall) state_next = afa_pkg::S_CHECK;
            afa_pkg::S_CHECK:
            begin
                if (req_reg.opcode == afa_pkg::OP_ALLOC)
                begin
                    if (size == 48'd0 || gen_bad || cap_reg == 48'd0 || !is_p2)
                        state_next = afa_pkg::S_DONE;
                    else if (count_reg == '0)
                        state_next = afa_pkg::S_FINAL;
                    else
                        state_next = afa_pkg::S_ALIGN;
                end
                else if (req_reg.opcode == afa_pkg::OP_RSVD || gen_bad
                         || count_reg == '0)
                    state_next = afa_pkg::S_DONE;
                else
                    state_next = afa_pkg::S_MATCH;
            end
            afa_pkg::S_ALIGN:
                state_next = (add_s[47:0] > AMASK - 48'd0 || add_s[48])
                             ? afa_pkg::S_DONE : afa_pkg::S_FIT;
            afa_pkg::S_FIT:
                if (!fit_ok) state_next = afa_pkg::S_DONE;
                else if (add_s[47:0] <= e_off) state_next = afa_pkg::S_FFIT;
                else state_next = afa_pkg::S_GAP;
            afa_pkg::S_GAP:
                if (add_s[48] || add_s[47:0] > AMASK) state_next = afa_pkg::S_DONE;
                else if (idx_reg + CW'(1) >= count_reg) state_next = afa_pkg::S_FINAL;
                else state_next = afa_pkg::S_ALIGN;
            afa_pkg::S_FINAL:
                state_next = (add_s[48] || add_s[47:0] > AMASK)
                             ? afa_pkg::S_DONE : afa_pkg::S_FFIT;
            afa_pkg::S_FFIT:
                if (!fit_ok || count_reg >= MAXC || nid_reg == 64'd0
                    || nid_reg == '1)
                    state_next = afa_pkg::S_DONE;
                else state_next = afa_pkg::S_INS;
            afa_pkg::S_INS:
                if (idx_next == idx_reg) state_next = afa_pkg::S_DONE;
            afa_pkg::S_MATCH:
                // Release of the last entry needs no shifting
                if (e_id == req_reg.handle_id && e_off == hoff && e_size == size
                    && e_align == align)
                    state_next = (req_reg.opcode == afa_pkg::OP_RELEASE
                                  && idx_reg + CW'(1) < count_reg)
                                 ? afa_pkg::S_DEL : afa_pkg::S_DONE;
                else if (idx_reg + CW'(1) >= count_reg) state_next = afa_pkg::S_DONE;
            afa_pkg::S_DEL:
                if (idx_reg + CW'(1) >= count_reg) state_next = afa_pkg::S_DONE;
            afa_pkg::S_DONE: state_next = afa_pkg::S_IDLE;
            default: state_next = afa_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs; table read address follows idx_next
    always_comb
    begin
        idx_next   = idx_reg;
        cand_next  = cand_reg;
        count_next = count_reg;
        nid_next   = nid_reg;
        live_next  = live_reg;
        odata_next = odata_reg;
        we         = 1'b0;
        waddr      = idx_reg[IW-1:0];
        wdata      = rdata;
        case (state_reg)
            afa_pkg::S_IDLE:
            begin
                idx_next  = '0;
                cand_next = '0;
            end
            afa_pkg::S_CHECK:
            begin
                odata_next.status        = afa_pkg::ST_OK;
                odata_next.result_id     = '0;
                odata_next.result_offset = '0;
                if (req_reg.opcode == afa_pkg::OP_ALLOC)
                begin
                    if (size == 48'd0 || gen_bad || cap_reg == 48'd0 || !is_p2)
                        odata_next.status = (req_reg.req_generation != epoch_reg
                            && req_reg.req_generation != 64'd0)
                            ? afa_pkg::ST_STALE : afa_pkg::ST_INVALID;
                end
                else if (req_reg.opcode == afa_pkg::OP_RSVD)
                    odata_next.status = afa_pkg::ST_INVALID;
                else if (gen_bad)
                    odata_next.status = afa_pkg::ST_STALE;
                else if (count_reg == '0)
                    odata_next.status = afa_pkg::ST_NOTFOUND;
            end
            afa_pkg::S_ALIGN:
            begin
                cand_next = add_s[47:0];
                if (add_s[48] || add_s[47:0] > AMASK)
                    odata_next.status = afa_pkg::ST_OOM;
            end
            afa_pkg::S_FIT:
                if (!fit_ok) odata_next.status = afa_pkg::ST_OOM;
            afa_pkg::S_GAP:
            begin
                cand_next = add_s[47:0];
                if (add_s[48] || add_s[47:0] > AMASK)
                    odata_next.status = afa_pkg::ST_OOM;
                else if (idx_reg + CW'(1) < count_reg)
                    idx_next = idx_reg + CW'(1);
            end
            afa_pkg::S_FINAL:
            begin
                cand_next = add_s[47:0];
                if (add_s[48] || add_s[47:0] > AMASK)
                    odata_next.status = afa_pkg::ST_OOM;
            end
            afa_pkg::S_FFIT:
            begin
                // Walk shifting from the top entry down to the insert point
                if (!fit_ok || count_reg >= MAXC || nid_reg == 64'd0
                    || nid_reg == '1)
                    odata_next.status = afa_pkg::ST_OOM;
                else
                    idx_next = count_reg;
            end
            afa_pkg::S_INS:
            begin
                // rdata holds entry idx-1 when idx>0
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                if (idx_reg != '0 && e_off >= cand_reg[47:0])
                begin
                    wdata    = rdata;
                    idx_next = idx_reg - CW'(1);
                end
                else
                begin
                    wdata = {nid_reg, cand_reg[47:0], size, align};
                    odata_next.result_id     = nid_reg;
                    odata_next.result_offset = cand_reg[47:0];
                    nid_next   = nid_reg + 64'd1;
                    count_next = count_reg + CW'(1);
                    live_next  = (live_reg + size) & AMASK;
                end
            end
            afa_pkg::S_MATCH:
                if (e_id == req_reg.handle_id && e_off == hoff && e_size == size
                    && e_align == align)
                begin
                    if (req_reg.opcode == afa_pkg::OP_RELEASE)
                    begin
                        live_next = (live_reg - e_size) & AMASK;
                        if (idx_reg + CW'(1) >= count_reg)
                            count_next = count_reg - CW'(1);
                        else
                            idx_next = idx_reg + CW'(1);
                    end
                end
                else if (idx_reg + CW'(1) >= count_reg)
                    odata_next.status = afa_pkg::ST_NOTFOUND;
                else
                    idx_next = idx_reg + CW'(1);
            afa_pkg::S_DEL:
            begin
                // rdata holds entry idx; move it down one place
                we    = 1'b1;
                waddr = IW'(idx_reg - CW'(1));
                wdata = rdata;
                if (idx_reg + CW'(1) >= count_reg)
                    count_next = count_reg - CW'(1);
                else
                    idx_next = idx_reg + CW'(1);
            end
            afa_pkg::S_DONE: odata_next.bytes_in_use = live_reg;
            default: ;
        endcase
    end

    // Read address: insert walk reads one below the slot being written
    always_comb
    begin
        if (state_next == afa_pkg::S_INS && idx_next != '0)
            raddr = IW'(idx_next - CW'(1));
        else
            raddr = idx_next[IW-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afa_pkg::S_IDLE;
            cap_reg   <= '0;
            epoch_reg <= '0;
            count_reg <= '0;
            nid_reg   <= 64'd1;
            live_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == afa_pkg::S_DONE)
                oval_reg <= 1'b1;
            else if (oval_reg && !out_stall)
                oval_reg <= 1'b0;
            if (cfg_valid && cfg_ready && cfg_index == afa_pkg::REG_CAPACITY)
                cap_reg <= cfg_data[47:0];
            // Epoch write takes effect only on an empty table
            if (cfg_valid && cfg_ready && cfg_index == afa_pkg::REG_EPOCH
                && count_reg == '0)
            begin
                epoch_reg <= cfg_data;
                nid_reg   <= 64'd1;
                live_reg  <= '0;
            end
            else
            begin
                nid_reg   <= nid_next;
                live_reg  <= live_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cand_reg  <= cand_next;
        odata_reg <= odata_next;
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    `AFA_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= MAXC, "table count overflow")
    `AFA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != afa_pkg::S_IDLE, in_stall, "accept while busy")
    `AFA_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == afa_pkg::S_DONE, out_valid, "result lost")
endmodule
